@@ hdl/art_pkg.sv @@
// Shared types and codes for the allocation region tracker.
package art_pkg;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_LOAD  = 2'd2;
  localparam logic [1:0] KIND_STORE = 2'd3;

  localparam logic [2:0] ST_IGNORED      = 3'd0;
  localparam logic [2:0] ST_ALLOC_OK     = 3'd1;
  localparam logic [2:0] ST_ALLOC_FULL   = 3'd2;
  localparam logic [2:0] ST_FREE_KNOWN   = 3'd3;
  localparam logic [2:0] ST_FREE_UNKNOWN = 3'd4;
  localparam logic [2:0] ST_HIT          = 3'd5;
  localparam logic [2:0] ST_MISS         = 3'd6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] address;
    logic [39:0] region_bytes;
    logic [7:0]  tag_id;
  } art_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        is_store;
    logic [39:0] offset;
    logic [63:0] found_start;
    logic [39:0] found_size;
    logic [7:0]  found_tag;
  } art_out_t;

  // Transaction walking down the cell row with the partial search results.
  typedef struct packed {
    logic        active;
    logic [1:0]  kind;
    logic [63:0] addr;
    logic [39:0] size;
    logic [7:0]  tag;
    logic        exact_hit;
    logic [39:0] exact_size;
    logic [7:0]  exact_tag;
    logic        empty_hit;
    logic        floor_hit;
    logic [63:0] floor_start;
    logic [39:0] floor_size;
    logic [7:0]  floor_tag;
    logic        floor_freed;
  } art_token_t;

  // Table update broadcast to every cell; the cell with the matching index takes it.
  typedef struct packed {
    logic        en;
    logic        set_freed;
    logic [63:0] start;
    logic [39:0] size;
    logic [7:0]  tag;
  } art_wr_t;

endpackage

@@ hdl/allocation_region_tracker_top.sv @@
// Allocation region tracker: row of entry cells searched by a walking token.
// The token is registered in every cell in turn; done is registered from the last cell's token.
// Only one transaction is in the row at a time; the token visits one cell per cycle.
// busy is high from accept until the result strobe; start is ignored while busy.
// The result is strobed for one cycle on done; the receiver cannot stall.
// Reset clears all entry valid bits, busy and done; no clearing pass is needed.
module allocation_region_tracker_top #(
  parameter int REGIONS   = 64,
  parameter int SIZE_BITS = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  art_pkg::art_in_t  cmd,
  output logic              done,
  output art_pkg::art_out_t result
);
  import art_pkg::*;

  localparam int IDX_W  = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int SIZE_W = (SIZE_BITS < 40) ? SIZE_BITS : 40;
  localparam logic [39:0] SIZE_MASK = 40'((41'd1 << SIZE_W) - 41'd1);

  art_token_t       head;
  art_token_t       tok    [REGIONS];
  logic [IDX_W-1:0] ex_idx [REGIONS];
  logic [IDX_W-1:0] em_idx [REGIONS];
  art_token_t       last;
  art_wr_t          wr;
  logic [IDX_W-1:0] wr_idx;
  art_out_t         res_next;
  logic             accept;
  logic [63:0]      diff;

  assign accept = start && !busy;

  always_comb begin
    head             = '0;
    head.active      = accept;
    head.kind        = cmd.kind;
    head.addr        = cmd.address;
    head.size        = cmd.region_bytes & SIZE_MASK;
    head.tag         = cmd.tag_id;
  end

  for (genvar i = 0; i < REGIONS; i++) begin : g_cell
    art_cell #(
      .INDEX  (i),
      .IDX_W  (IDX_W),
      .SIZE_W (SIZE_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .tok_in     ((i == 0) ? head : tok[(i == 0) ? 0 : i - 1]),
      .ex_idx_in  ((i == 0) ? '0 : ex_idx[(i == 0) ? 0 : i - 1]),
      .em_idx_in  ((i == 0) ? '0 : em_idx[(i == 0) ? 0 : i - 1]),
      .tok_out    (tok[i]),
      .ex_idx_out (ex_idx[i]),
      .em_idx_out (em_idx[i]),
      .wr         (wr),
      .wr_idx     (wr_idx)
    );
  end

  assign last = tok[REGIONS-1];
  assign diff = last.addr - last.floor_start;

  always_comb begin
    res_next     = '0;
    wr           = '0;
    wr.start     = last.addr;
    wr.size      = last.size;
    wr.tag       = last.tag;
    wr_idx       = last.exact_hit ? ex_idx[REGIONS-1] : em_idx[REGIONS-1];
    case (last.kind)
      KIND_ALLOC: begin
        if (last.addr != 64'd0 && last.size != 40'd0) begin
          if (last.exact_hit || last.empty_hit) begin
            wr.en                = last.active;
            res_next.status      = ST_ALLOC_OK;
            res_next.found_start = last.addr;
            res_next.found_size  = last.size;
            res_next.found_tag   = last.tag;
          end else begin
            res_next.status = ST_ALLOC_FULL;
          end
        end
      end
      KIND_FREE: begin
        if (last.addr != 64'd0) begin
          if (last.exact_hit) begin
            wr.en                = last.active;
            wr.set_freed         = 1'b1;
            res_next.status      = ST_FREE_KNOWN;
            res_next.found_start = last.addr;
            res_next.found_size  = last.exact_size;
            res_next.found_tag   = last.exact_tag;
          end else begin
            res_next.status    = ST_FREE_UNKNOWN;
            res_next.found_tag = last.tag;
          end
        end
      end
      default: begin
        res_next.is_store = (last.kind == KIND_STORE);
        res_next.status   = ST_MISS;
        if (last.floor_hit && !last.floor_freed && diff < 64'(last.floor_size)) begin
          res_next.status      = ST_HIT;
          res_next.offset      = diff[39:0];
          res_next.found_start = last.floor_start;
          res_next.found_size  = last.floor_size;
          res_next.found_tag   = last.floor_tag;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= last.active;
      if (accept) begin
        busy <= 1'b1;
      end else if (last.active) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("busy not set after accept");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("strobe while still busy");
  a_token_done: assert property (@(posedge clk) disable iff (rst)
    last.active |=> done) else $error("token left the row without a strobe");
  a_done_had_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("strobe without a transaction");
  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_HIT) |-> (result.offset < result.found_size))
    else $error("hit offset outside region");

endmodule

@@ hdl/art_cell.sv @@
// One table entry plus one stage of the search token pipeline.
module art_cell #(
  parameter int INDEX  = 0,
  parameter int IDX_W  = 6,
  parameter int SIZE_W = 40
) (
  input  logic                clk,
  input  logic                rst,
  input  art_pkg::art_token_t tok_in,
  input  logic [IDX_W-1:0]    ex_idx_in,
  input  logic [IDX_W-1:0]    em_idx_in,
  output art_pkg::art_token_t tok_out,
  output logic [IDX_W-1:0]    ex_idx_out,
  output logic [IDX_W-1:0]    em_idx_out,
  input  art_pkg::art_wr_t    wr,
  input  logic [IDX_W-1:0]    wr_idx
);
  import art_pkg::*;

  logic              valid;
  logic [63:0]       start;
  logic [SIZE_W-1:0] size;
  logic [7:0]        tag;
  logic              freed;

  art_token_t       tok_next;
  logic [IDX_W-1:0] ex_idx_next;
  logic [IDX_W-1:0] em_idx_next;
  logic             my_write;

  always_comb begin
    tok_next    = tok_in;
    ex_idx_next = ex_idx_in;
    em_idx_next = em_idx_in;
    if (!tok_in.exact_hit && valid && start == tok_in.addr) begin
      tok_next.exact_hit  = 1'b1;
      tok_next.exact_size = 40'(size);
      tok_next.exact_tag  = tag;
      ex_idx_next         = IDX_W'(INDEX);
    end
    if (!tok_in.empty_hit && !valid) begin
      tok_next.empty_hit = 1'b1;
      em_idx_next        = IDX_W'(INDEX);
    end
    // greatest start not above the address, freed entries included
    if (valid && start <= tok_in.addr &&
        (!tok_in.floor_hit || start > tok_in.floor_start)) begin
      tok_next.floor_hit   = 1'b1;
      tok_next.floor_start = start;
      tok_next.floor_size  = 40'(size);
      tok_next.floor_tag   = tag;
      tok_next.floor_freed = freed;
    end
  end

  assign my_write = wr.en && (wr_idx == IDX_W'(INDEX));

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
    ex_idx_out <= ex_idx_next;
    em_idx_out <= em_idx_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (my_write && !wr.set_freed) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (my_write) begin
      if (wr.set_freed) begin
        freed <= 1'b1;
      end else begin
        start <= wr.start;
        size  <= wr.size[SIZE_W-1:0];
        tag   <= wr.tag;
        freed <= 1'b0;
      end
    end
  end

endmodule

@@ verif/region_table_checker.sv @@
// Checker for the allocation region tracker: predicts each result and compares it.
`timescale 1ns / 1ps

module region_table_checker #(
  parameter int REGIONS   = 64,
  parameter int SIZE_BITS = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  art_pkg::art_in_t  cmd,
  input  logic              done,
  input  art_pkg::art_out_t result,
  output int                mismatches,
  output int                pending
);
  import art_pkg::*;

  localparam logic [63:0] SIZE_MASK =
    (SIZE_BITS >= 64) ? '1 : ((64'd1 << SIZE_BITS) - 64'd1);

  // Shadow copy of the region table.
  logic        slot_live     [REGIONS];
  logic [63:0] slot_base     [REGIONS];
  logic [63:0] slot_len      [REGIONS];
  logic [7:0]  slot_tag      [REGIONS];
  logic        slot_released [REGIONS];

  art_out_t expected_replies[$];
  art_out_t want_reply;

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h want %h", field, got, want));
    end
  endtask

  function automatic int find_exact(logic [63:0] base);
    for (int i = 0; i < REGIONS; i++) begin
      if (slot_live[i] && slot_base[i] == base) return i;
    end
    return -1;
  endfunction

  // Applies one transaction to the shadow table and returns its result.
  function automatic art_out_t predict_reply(art_in_t c);
    art_out_t    r;
    logic [63:0] sz;
    logic [63:0] d;
    int          slot;
    r  = '0;
    sz = {24'b0, c.region_bytes} & SIZE_MASK;
    case (c.kind)
      KIND_ALLOC: begin
        if (c.address != '0 && sz != '0) begin
          slot = find_exact(c.address);
          if (slot < 0) begin
            for (int i = 0; i < REGIONS; i++) begin
              if (!slot_live[i]) begin
                slot = i;
                break;
              end
            end
          end
          if (slot < 0) begin
            r.status = ST_ALLOC_FULL;
          end else begin
            slot_live[slot]     = 1'b1;
            slot_base[slot]     = c.address;
            slot_len[slot]      = sz;
            slot_tag[slot]      = c.tag_id;
            slot_released[slot] = 1'b0;
            r.status      = ST_ALLOC_OK;
            r.found_start = c.address;
            r.found_size  = sz[39:0];
            r.found_tag   = c.tag_id;
          end
        end
      end
      KIND_FREE: begin
        if (c.address != '0) begin
          slot = find_exact(c.address);
          if (slot >= 0) begin
            slot_released[slot] = 1'b1;
            r.status      = ST_FREE_KNOWN;
            r.found_start = slot_base[slot];
            r.found_size  = slot_len[slot][39:0];
            r.found_tag   = slot_tag[slot];
          end else begin
            r.status    = ST_FREE_UNKNOWN;
            r.found_tag = c.tag_id;
          end
        end
      end
      default: begin
        r.is_store = (c.kind == KIND_STORE);
        r.status   = ST_MISS;
        // nearest start at or below the address; freed entries still win the search
        slot = -1;
        for (int i = 0; i < REGIONS; i++) begin
          if (slot_live[i] && slot_base[i] <= c.address &&
              (slot < 0 || slot_base[i] > slot_base[slot])) begin
            slot = i;
          end
        end
        if (slot >= 0 && !slot_released[slot]) begin
          d = c.address - slot_base[slot];
          if (d < slot_len[slot]) begin
            r.status      = ST_HIT;
            r.offset      = d[39:0];
            r.found_start = slot_base[slot];
            r.found_size  = slot_len[slot][39:0];
            r.found_tag   = slot_tag[slot];
          end
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REGIONS; i++) begin
        slot_live[i]     = 1'b0;
        slot_base[i]     = '0;
        slot_len[i]      = '0;
        slot_tag[i]      = '0;
        slot_released[i] = 1'b0;
      end
      expected_replies.delete();
    end else begin
      if (done) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("result strobe with no transaction outstanding");
        end else begin
          want_reply = expected_replies.pop_front();
          check_field("status", 64'(result.status), 64'(want_reply.status));
          check_field("is_store", 64'(result.is_store), 64'(want_reply.is_store));
          check_field("offset", 64'(result.offset), 64'(want_reply.offset));
          check_field("found_start", result.found_start, want_reply.found_start);
          check_field("found_size", 64'(result.found_size), 64'(want_reply.found_size));
          check_field("found_tag", 64'(result.found_tag), 64'(want_reply.found_tag));
        end
      end
      if (start && !busy) begin
        expected_replies.push_back(predict_reply(cmd));
      end
    end
    pending <= expected_replies.size();
  end

endmodule

@@ verif/testbench.sv @@
// Top of the allocation region tracker testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import art_pkg::*;

  localparam int          REGIONS      = 64;
  localparam int          SIZE_BITS    = 40;
  localparam int          RANDOM_ITEMS = 750;
  localparam int          POOL_MAX     = 90;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam logic [63:0] CLUSTER_BASE = 64'h0000_5555_0000_0000;

  logic     clk = 1'b0;
  logic     rst;
  logic     start;
  logic     busy;
  art_in_t  cmd;
  logic     done;
  art_out_t result;
  int       mismatches;
  int       pending;
  int       cycle_count;
  bit       allow_idle;

  // Starts handed out so far, with the size last sent for each.
  logic [63:0] pool_start[$];
  logic [39:0] pool_len[$];

  art_in_t next_cmd;

  allocation_region_tracker_top #(
    .REGIONS  (REGIONS),
    .SIZE_BITS(SIZE_BITS)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .result(result)
  );

  region_table_checker #(
    .REGIONS  (REGIONS),
    .SIZE_BITS(SIZE_BITS)
  ) i_checker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic art_in_t mk(logic [1:0] kind, logic [63:0] addr,
                                 logic [39:0] bytes, logic [7:0] tag);
    art_in_t c;
    c.kind         = kind;
    c.address      = addr;
    c.region_bytes = bytes;
    c.tag_id       = tag;
    return c;
  endfunction

  // Drives one transaction and returns once it is accepted, at times after an idle gap.
  task automatic issue(art_in_t c);
    cmd   <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (allow_idle && $urandom_range(0, 99) < 13) begin
      start <= 1'b0;
      repeat ($urandom_range(1, REGIONS + 10)) @(posedge clk);
    end
  endtask

  task automatic rand_cmd(output art_in_t c);
    int          roll;
    int          idx;
    int          bits;
    logic [63:0] base;
    logic [63:0] span;
    bits           = $urandom_range(1, 40);
    roll           = $urandom_range(0, 99);
    c.kind         = KIND_ALLOC;
    c.address      = {$urandom, $urandom};
    c.region_bytes = 40'({$urandom, $urandom}) & ((40'd1 << bits) - 40'd1);
    c.tag_id       = 8'($urandom);
    if (c.address == '0) c.address = 64'd1;
    if (c.region_bytes == '0) c.region_bytes = 40'd1;
    if (roll < 8) begin
      // noise: null starts, zero sizes, unknown frees, wild accesses
      case ($urandom_range(0, 4))
        0: c.address = '0;
        1: c.region_bytes = '0;
        2: begin
          c.kind    = KIND_FREE;
          c.address = '0;
        end
        3: c.kind = KIND_FREE;
        default: c.kind = $urandom_range(0, 1) ? KIND_LOAD : KIND_STORE;
      endcase
    end else if (roll < 40 || pool_start.size() == 0) begin
      if (pool_start.size() == 0 ||
          (pool_start.size() < POOL_MAX && $urandom_range(0, 99) < 40)) begin
        if ($urandom_range(0, 1)) begin
          // clustered small regions so neighbors and overlaps show up
          c.address      = CLUSTER_BASE + 64'($urandom_range(1, 4096)) * 64;
          c.region_bytes = c.region_bytes & 40'hFFF;
          if (c.region_bytes == '0) c.region_bytes = 40'd1;
        end
        pool_start.push_back(c.address);
        pool_len.push_back(c.region_bytes);
      end else begin
        idx            = $urandom_range(0, pool_start.size() - 1);
        c.address      = pool_start[idx];
        c.region_bytes = (c.address[63:16] == CLUSTER_BASE[63:16]) ?
                         (c.region_bytes & 40'hFFF) | 40'd1 : c.region_bytes;
        pool_len[idx]  = c.region_bytes;
      end
    end else if (roll < 52) begin
      c.kind    = KIND_FREE;
      c.address = pool_start[$urandom_range(0, pool_start.size() - 1)];
    end else begin
      c.kind = $urandom_range(0, 1) ? KIND_LOAD : KIND_STORE;
      idx    = $urandom_range(0, pool_start.size() - 1);
      base   = pool_start[idx];
      span   = {24'b0, pool_len[idx]};
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: c.address = base + ({$urandom, $urandom} % span);
        6, 7: c.address = base + span + 64'($urandom_range(0, 3));
        8: c.address = base - 64'($urandom_range(1, 4));
        default: ;
      endcase
    end
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    cmd         = '0;
    allow_idle  = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, ignored items, extremes, replace, revive, overlap
    issue(mk(KIND_LOAD,  64'h0, 40'h0, 8'h00));
    issue(mk(KIND_ALLOC, 64'h0, 40'h100, 8'h01));
    issue(mk(KIND_ALLOC, 64'h1000, 40'h0, 8'h02));
    issue(mk(KIND_FREE,  64'h0, 40'h0, 8'h03));
    issue(mk(KIND_FREE,  64'h1000, 40'h0, 8'hA5));
    issue(mk(KIND_ALLOC, 64'h1000, 40'h100, 8'h11));
    issue(mk(KIND_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 8'hFF));
    issue(mk(KIND_ALLOC, 64'h2000, 40'h10, 8'h22));
    issue(mk(KIND_LOAD,  64'h1000, 40'h0, 8'h00));
    issue(mk(KIND_STORE, 64'h10FF, 40'h0, 8'h00));
    issue(mk(KIND_LOAD,  64'h1100, 40'h0, 8'h00));
    issue(mk(KIND_STORE, 64'h0FFF, 40'h0, 8'h00));
    issue(mk(KIND_LOAD,  64'hFFFF_FFFF_FFFF_FFFF, 40'h0, 8'h00));
    issue(mk(KIND_FREE,  64'h2000, 40'h0, 8'h5A));
    issue(mk(KIND_LOAD,  64'h2004, 40'h0, 8'h00));
    issue(mk(KIND_FREE,  64'h2000, 40'h0, 8'h00));
    issue(mk(KIND_ALLOC, 64'h1000, 40'h20, 8'h33));
    issue(mk(KIND_LOAD,  64'h1080, 40'h0, 8'h00));
    issue(mk(KIND_ALLOC, 64'h2000, 40'h40, 8'h44));
    issue(mk(KIND_STORE, 64'h203F, 40'h0, 8'h00));
    // wide region below a small one: nearest start decides, so this misses
    issue(mk(KIND_ALLOC, 64'h1800, 40'h1000, 8'h55));
    issue(mk(KIND_LOAD,  64'h2100, 40'h0, 8'h00));
    issue(mk(KIND_ALLOC, 64'h8000_0000_0000_0000, 40'h1, 8'h80));
    issue(mk(KIND_STORE, 64'h8000_0000_0000_0001, 40'h0, 8'h00));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      allow_idle = !(n >= 250 && n < 420);
      rand_cmd(next_cmd);
      issue(next_cmd);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (REGIONS + 10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/art_pkg.sv
hdl/art_cell.sv
hdl/allocation_region_tracker_top.sv
verif/region_table_checker.sv
verif/testbench.sv
